@@ hdl/schunk_pkg.sv @@
// schunk_pkg: beat types, character codes and register indexes of the sentence chunker
// no dependencies; imported by the chunker top level
package schunk_pkg;

  localparam int TextW   = 8;
  localparam int DocW    = 16;
  localparam int PosOutW = 24;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgTargetSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOverlap    = 2'd1;

  localparam logic [CfgW-1:0] TargetReset  = 16'd512;
  localparam logic [CfgW-1:0] OverlapReset = 16'd0;

  localparam logic [TextW-1:0] ChPeriod = 8'h2e;
  localparam logic [TextW-1:0] ChBang   = 8'h21;
  localparam logic [TextW-1:0] ChQuery  = 8'h3f;
  localparam logic [TextW-1:0] ChSpace  = 8'h20;
  localparam logic [TextW-1:0] ChLf     = 8'h0a;
  localparam logic [TextW-1:0] ChCr     = 8'h0d;
  localparam logic [TextW-1:0] ChTab    = 8'h09;

  typedef struct packed {
    logic [TextW-1:0] text_byte;
    logic [DocW-1:0]  doc_number;
    logic             end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [DocW-1:0]    chunk_doc;
    logic [PosOutW-1:0] chunk_offset;
    logic [PosOutW-1:0] chunk_length;
    logic               forced_break;
    logic               final_chunk;
  } out_beat_t;

endpackage

@@ hdl/schunk_ram.sv @@
// schunk_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the sentence boundary window of the chunker
module schunk_ram #(
  parameter int Width = 24,
  parameter int Depth = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sentence_chunker_with_overlap_top.sv @@
// sentence_chunker_with_overlap_top: byte-serial sentence finder and greedy chunker with overlap
// depends on schunk_pkg and schunk_ram (circular window of sentence boundaries)
// each byte is registered and counted, then the held boundaries are rescanned for a chunk
// to close (no rescan with a lone boundary); a document's first byte first opens the window
// and its final chunk is emitted last; a closed chunk is emitted, overlap sentences are walked
// back up to the overlap limit and the window is rescanned; a full output register stalls emit
// one byte in flight at a time; results wait in an output register while the next byte enters
// reset: asynchronous, no document open, chunk target 512, overlap 0; window needs no clearing
module sentence_chunker_with_overlap_top
  import schunk_pkg::*;
#(
  parameter int OffsetBits   = 24,
  parameter int MaxSentences = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_beat_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_beat_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int Depth = MaxSentences + 1;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int AccW  = ((OffsetBits > CfgW) ? OffsetBits : CfgW) + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OPEN, ST_BUMP, ST_SC_INIT, ST_SC_REQ, ST_SC_USE, ST_DECIDE,
    ST_EMIT, ST_AV_CHK, ST_AV_REQ, ST_AV_USE, ST_AV_DONE, ST_FINISH
  } state_e;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] p);
    return (p == '0) ? IdxW'(Depth - 1) : p - IdxW'(1);
  endfunction

  state_e               state_q;
  logic [CfgW-1:0]      target_q, overlap_q;
  logic [TextW-1:0]     byte_q;
  logic [DocW-1:0]      doc_in_q, doc_q;
  logic                 eot_q;
  logic [OffsetBits-1:0] pos_q, hv_q, last_q, cur_q, len_q;
  logic                 ap_q;
  logic [IdxW-1:0]      head_q, rp_q, ep_q, wp_q;
  logic [CntW-1:0]      cnt_q, e_q, start_q;
  logic [AccW-1:0]      acc_q;
  logic                 forced_q, fin_q;
  logic                 ovalid_q;
  out_beat_t            out_q;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [OffsetBits-1:0] ram_wdata, rd;
  logic [OffsetBits-1:0] pos_n, diff;
  logic                  is_ws, is_punct, app_ws, app;
  logic [IdxW:0]         tsum;
  logic [IdxW-1:0]       tail;
  logic                  av_mode;
  logic [AccW-1:0]       sum, limit;
  logic                  brk;

  schunk_ram #(
    .Width(OffsetBits),
    .Depth(Depth)
  ) u_bounds (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rp_q),
    .rdata_o(rd)
  );

  always_comb begin
    pos_n    = pos_q + OffsetBits'(1);
    is_ws    = (byte_q == ChSpace) || (byte_q == ChLf) || (byte_q == ChCr) ||
               (byte_q == ChTab);
    is_punct = (byte_q == ChPeriod) || (byte_q == ChBang) || (byte_q == ChQuery);
    app_ws   = ap_q && is_ws;
    app      = (app_ws || (eot_q && (last_q != pos_n))) && (cnt_q < CntW'(Depth));
    tsum     = (IdxW+1)'(head_q) + (IdxW+1)'(cnt_q);
    tail     = (tsum >= (IdxW+1)'(Depth)) ? IdxW'(tsum - (IdxW+1)'(Depth)) : IdxW'(tsum);
  end

  // shared span unit: boundary difference, running sum and limit compare
  always_comb begin
    av_mode = (state_q == ST_AV_USE);
    diff    = av_mode ? (cur_q - rd) : (rd - cur_q);
    sum     = acc_q + AccW'(diff);
    limit   = av_mode ? AccW'(overlap_q) : AccW'(target_q);
    brk     = (sum > limit) && (av_mode || (acc_q != '0));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = pos_n;
    case (state_q)
      ST_OPEN: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
      end
      ST_BUMP: begin
        ram_we = app;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TargetReset;
      overlap_q <= OverlapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTargetSize: target_q  <= cfg_wdata_i;
        CfgOverlap:    overlap_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      byte_q   <= '0;
      doc_in_q <= '0;
      doc_q    <= '0;
      eot_q    <= 1'b0;
      pos_q    <= '0;
      hv_q     <= '0;
      last_q   <= '0;
      cur_q    <= '0;
      len_q    <= '0;
      ap_q     <= 1'b0;
      head_q   <= '0;
      rp_q     <= '0;
      ep_q     <= '0;
      wp_q     <= '0;
      cnt_q    <= '0;
      e_q      <= '0;
      start_q  <= '0;
      acc_q    <= '0;
      forced_q <= 1'b0;
      fin_q    <= 1'b0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
    end else begin
      if (ovalid_q && out_ready_i && (state_q != ST_EMIT)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            byte_q   <= in_data_i.text_byte;
            doc_in_q <= in_data_i.doc_number;
            eot_q    <= in_data_i.end_of_text;
            state_q  <= (cnt_q == '0) ? ST_OPEN : ST_BUMP;
          end
        end
        ST_OPEN: begin
          doc_q   <= doc_in_q;
          head_q  <= '0;
          cnt_q   <= CntW'(1);
          hv_q    <= '0;
          last_q  <= '0;
          pos_q   <= '0;
          ap_q    <= 1'b0;
          state_q <= ST_BUMP;
        end
        ST_BUMP: begin
          pos_q <= pos_n;
          ap_q  <= is_punct;
          if (app) begin
            cnt_q  <= cnt_q + CntW'(1);
            last_q <= pos_n;
          end
          state_q <= ST_SC_INIT;
        end
        ST_SC_INIT: begin
          if (cnt_q < CntW'(2)) begin
            state_q <= ST_FINISH;
          end else begin
            acc_q   <= '0;
            cur_q   <= hv_q;
            e_q     <= '0;
            ep_q    <= head_q;
            rp_q    <= idx_inc(head_q);
            state_q <= ST_SC_REQ;
          end
        end
        ST_SC_REQ: begin
          state_q <= av_mode ? ST_AV_USE : ST_SC_USE;
        end
        ST_SC_USE: begin
          if (brk) begin
            state_q <= ST_DECIDE;
          end else begin
            acc_q <= sum;
            cur_q <= rd;
            ep_q  <= rp_q;
            e_q   <= e_q + CntW'(1);
            if (e_q + CntW'(1) == cnt_q - CntW'(1)) begin
              state_q <= ST_DECIDE;
            end else begin
              rp_q    <= idx_inc(rp_q);
              state_q <= ST_SC_REQ;
            end
          end
        end
        ST_DECIDE: begin
          len_q <= OffsetBits'(acc_q);
          fin_q <= 1'b0;
          if (e_q < cnt_q - CntW'(1)) begin
            forced_q <= 1'b0;
            state_q  <= ST_EMIT;
          end else if (!eot_q && (cnt_q == CntW'(Depth))) begin
            forced_q <= 1'b1;
            state_q  <= ST_EMIT;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_EMIT: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q           <= 1'b1;
            out_q.chunk_doc    <= doc_q;
            out_q.chunk_offset <= PosOutW'(hv_q);
            out_q.chunk_length <= PosOutW'(len_q);
            out_q.forced_break <= forced_q;
            out_q.final_chunk  <= fin_q;
            if (fin_q) begin
              cnt_q   <= '0;
              pos_q   <= '0;
              ap_q    <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              acc_q   <= '0;
              start_q <= e_q;
              wp_q    <= ep_q;
              state_q <= ST_AV_CHK;
            end
          end
        end
        ST_AV_CHK: begin
          if ((overlap_q != '0) && (start_q > CntW'(1))) begin
            rp_q    <= idx_dec(wp_q);
            state_q <= ST_AV_REQ;
          end else begin
            state_q <= ST_AV_DONE;
          end
        end
        ST_AV_REQ: begin
          state_q <= ST_AV_USE;
        end
        ST_AV_USE: begin
          if (brk) begin
            state_q <= ST_AV_DONE;
          end else begin
            acc_q   <= sum;
            start_q <= start_q - CntW'(1);
            cur_q   <= rd;
            wp_q    <= rp_q;
            state_q <= ST_AV_CHK;
          end
        end
        ST_AV_DONE: begin
          head_q  <= wp_q;
          cnt_q   <= cnt_q - start_q;
          hv_q    <= cur_q;
          state_q <= ST_SC_INIT;
        end
        ST_FINISH: begin
          if (eot_q) begin
            if (cnt_q >= CntW'(2)) begin
              len_q    <= last_q - hv_q;
              forced_q <= 1'b0;
              fin_q    <= 1'b1;
              state_q  <= ST_EMIT;
            end else begin
              cnt_q   <= '0;
              pos_q   <= '0;
              ap_q    <= 1'b0;
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/tb_sentence_chunker_with_overlap_top.sv @@
`timescale 1ns / 100ps
// tb_sentence_chunker_with_overlap_top: self-checking bench for the sentence chunker with overlap
// streams text beats and register writes, predicts every chunk in a small scoreboard class
// depends on schunk_pkg and sentence_chunker_with_overlap_top
module tb_sentence_chunker_with_overlap_top;
  import schunk_pkg::*;

  localparam int WindowDepth = 16;
  localparam int PosW        = 24;
  localparam int QuietCycles = 150;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 1000000;
  localparam int IdlePct     = 37;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  class chunk_scoreboard;
    logic [CfgW-1:0]  chunk_target;
    logic [CfgW-1:0]  overlap_size;
    logic [PosW-1:0]  byte_pos;
    bit               after_punct;
    logic [PosW-1:0]  bounds [WindowDepth+1];
    int unsigned      bound_cnt;
    logic [DocW-1:0]  doc_id;
    out_beat_t        chunks_due [$];
    int unsigned      mismatches;

    function new();
      chunk_target = TargetReset;
      overlap_size = OverlapReset;
      byte_pos     = '0;
      after_punct  = 1'b0;
      bound_cnt    = 0;
      doc_id       = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      if (idx == CfgTargetSize) chunk_target = value;
      else if (idx == CfgOverlap) overlap_size = value;
    endfunction

    function logic [PosW-1:0] span(int unsigned a, int unsigned b);
      return bounds[b] - bounds[a];
    endfunction

    function void add_bound(logic [PosW-1:0] pos);
      if (bound_cnt < WindowDepth + 1) begin
        bounds[bound_cnt] = pos;
        bound_cnt++;
      end
    endfunction

    function void push_chunk(logic [PosW-1:0] len, bit forced, bit last);
      out_beat_t c;
      c.chunk_doc    = doc_id;
      c.chunk_offset = bounds[0];
      c.chunk_length = len;
      c.forced_break = forced;
      c.final_chunk  = last;
      chunks_due = {chunks_due, c};
    endfunction

    // next chunk keeps trailing sentences that fit the overlap, but starts at least one later
    function void drop_to_overlap(int unsigned last);
      int unsigned start;
      int unsigned i;
      longint unsigned acc;
      longint unsigned s;
      start = last;
      acc = 0;
      if (overlap_size > 0) begin
        while (start > 1) begin
          s = span(start - 1, start);
          if (acc + s > overlap_size) break;
          acc += s;
          start--;
        end
      end
      for (i = start; i < bound_cnt; i++) bounds[i - start] = bounds[i];
      bound_cnt -= start;
    endfunction

    function void take_byte(in_beat_t beat);
      bit at_end;
      bit ws;
      int unsigned n;
      int unsigned e;
      longint unsigned acc;
      longint unsigned s;
      at_end = beat.end_of_text;
      ws = (beat.text_byte == ChSpace || beat.text_byte == ChLf ||
            beat.text_byte == ChCr || beat.text_byte == ChTab);
      if (bound_cnt == 0) begin
        doc_id      = beat.doc_number;
        byte_pos    = '0;
        after_punct = 1'b0;
        bounds[0]   = '0;
        bound_cnt   = 1;
      end
      byte_pos = byte_pos + 1'b1;
      if (after_punct && ws) add_bound(byte_pos);
      after_punct = (beat.text_byte == ChPeriod || beat.text_byte == ChBang ||
                     beat.text_byte == ChQuery);
      if (at_end && bounds[bound_cnt - 1] != byte_pos) add_bound(byte_pos);
      forever begin
        n = bound_cnt;
        e = 0;
        acc = 0;
        if (n < 2) break;
        while (e < n - 1) begin
          s = span(e, e + 1);
          if (acc > 0 && acc + s > chunk_target) break;
          acc += s;
          e++;
        end
        if (e == 0) e = 1;
        if (e < n - 1) begin
          push_chunk(span(0, e), 1'b0, 1'b0);
          drop_to_overlap(e);
        end else if (!at_end && n >= WindowDepth + 1) begin
          push_chunk(span(0, n - 1), 1'b1, 1'b0);
          drop_to_overlap(n - 1);
        end else begin
          break;
        end
      end
      if (at_end) begin
        if (bound_cnt >= 2) push_chunk(span(0, bound_cnt - 1), 1'b0, 1'b1);
        bound_cnt   = 0;
        byte_pos    = '0;
        after_punct = 1'b0;
      end
    endfunction

    function void report(string what, out_beat_t want, out_beat_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("chunk mismatch (%s): exp doc %h off %h len %h fb %b fin %b", what,
                 want.chunk_doc, want.chunk_offset, want.chunk_length,
                 want.forced_break, want.final_chunk);
      if (mismatches <= 10)
        $display("                      got doc %h off %h len %h fb %b fin %b",
                 got.chunk_doc, got.chunk_offset, got.chunk_length,
                 got.forced_break, got.final_chunk);
    endfunction

    function void check_chunk(out_beat_t got);
      out_beat_t want;
      if (chunks_due.size() == 0) begin
        report("none due", '0, got);
        return;
      end
      want = chunks_due.pop_front();
      if (got.chunk_doc !== want.chunk_doc || got.chunk_offset !== want.chunk_offset ||
          got.chunk_length !== want.chunk_length || got.forced_break !== want.forced_break ||
          got.final_chunk !== want.final_chunk)
        report("field", want, got);
    endfunction

    function void flush_leftover();
      while (chunks_due.size() > 0) report("never seen", chunks_due.pop_front(), '0);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               text_valid;
  logic               text_ready;
  in_beat_t           text_beat;
  logic               chunk_valid;
  logic               chunk_ready;
  out_beat_t          chunk_beat;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  chunk_scoreboard    chunk_check;
  bit                 calm;
  bit                 stall_request;
  logic [TextW-1:0]   doc_text [$];
  int unsigned        cycle_count;

  sentence_chunker_with_overlap_top #(
    .OffsetBits  (PosW),
    .MaxSentences(WindowDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (text_valid),
    .in_ready_o (text_ready),
    .in_data_i  (text_beat),
    .out_valid_o(chunk_valid),
    .out_ready_i(chunk_ready),
    .out_data_o (chunk_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sentence_chunker_with_overlap_top test failed");
    $finish;
  end

  // result side: random ready, one long hold on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    chunk_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && chunk_valid && chunk_ready) chunk_check.check_chunk(chunk_beat);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        chunk_ready <= 1'b0;
      end else begin
        chunk_ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  function automatic logic [TextW-1:0] word_byte();
    if ($urandom_range(4) == 0) return ChSpace;
    return 8'($urandom_range(8'h7a, 8'h61));
  endfunction

  function automatic logic [TextW-1:0] punct_byte();
    case ($urandom_range(2))
      0: return ChPeriod;
      1: return ChBang;
      default: return ChQuery;
    endcase
  endfunction

  function automatic logic [TextW-1:0] space_byte();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChLf;
      2: return ChCr;
      default: return ChTab;
    endcase
  endfunction

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) doc_text = {doc_text, s[i]};
  endtask

  task automatic send_beat(input in_beat_t beat);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < IdlePct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_beat  <= beat;
    do @(posedge clk); while (!text_ready);
    chunk_check.take_byte(beat);
  endtask

  // later beats carry junk doc numbers, which the block must ignore
  task automatic send_doc(input logic [DocW-1:0] doc);
    in_beat_t beat;
    int unsigned i;
    for (i = 0; i < doc_text.size(); i++) begin
      beat.text_byte   = doc_text[i];
      beat.doc_number  = (i == 0) ? doc : 16'($urandom_range(16'hffff));
      beat.end_of_text = (i == doc_text.size() - 1);
      send_beat(beat);
    end
    doc_text.delete();
  endtask

  task automatic wait_drained();
    if (text_valid) text_valid <= 1'b0;
    while (chunk_check.chunks_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_config(input logic [CfgW-1:0] tgt, input logic [CfgW-1:0] ovl);
    logic [CfgW-1:0] junk;
    junk = 16'($urandom_range(16'hffff));
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgTargetSize;
    cfg_wdata <= tgt;
    @(posedge clk);
    chunk_check.write_reg(CfgTargetSize, tgt);
    cfg_idx   <= CfgOverlap;
    cfg_wdata <= ovl;
    @(posedge clk);
    chunk_check.write_reg(CfgOverlap, ovl);
    cfg_idx   <= CfgSpare;
    cfg_wdata <= junk;
    @(posedge clk);
    chunk_check.write_reg(CfgSpare, junk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed sentences, some broken endings and raw noise bytes
  task automatic build_random_doc(input int unsigned doc_max, input int unsigned body_max);
    int unsigned len;
    int unsigned roll;
    len = $urandom_range(doc_max, 1);
    while (doc_text.size() < len) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        doc_text = {doc_text, 8'($urandom_range(8'hff))};
      end else begin
        repeat ($urandom_range(body_max, 0)) doc_text = {doc_text, word_byte()};
        if (roll < 90) begin
          doc_text = {doc_text, punct_byte()};
          doc_text = {doc_text, space_byte()};
        end else if (roll < 95) begin
          doc_text = {doc_text, punct_byte()};
        end else begin
          doc_text = {doc_text, space_byte()};
        end
      end
    end
    while (doc_text.size() > len) void'(doc_text.pop_back());
  endtask

  task automatic run_phase(input logic [CfgW-1:0] tgt, input logic [CfgW-1:0] ovl,
                           input int unsigned budget, input int unsigned doc_max,
                           input int unsigned body_max, input bit hold_rx,
                           input bit drain_docs);
    int unsigned sent;
    int unsigned docs;
    settle();
    write_config(tgt, ovl);
    if (hold_rx) stall_request = 1'b1;
    sent = 0;
    docs = 0;
    while (sent < budget) begin
      build_random_doc((budget - sent < doc_max) ? (budget - sent) : doc_max, body_max);
      sent += doc_text.size();
      docs++;
      send_doc(16'($urandom_range(16'hffff)));
      if (drain_docs && (docs == 1 || $urandom_range(2) == 0)) wait_drained();
    end
  endtask

  initial begin
    chunk_check   = new();
    calm          = 1'b0;
    stall_request = 1'b0;
    rst_n      <= 1'b0;
    text_valid <= 1'b0;
    text_beat  <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CfgTargetSize;
    cfg_wdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every punctuation and whitespace, text ending on a boundary, then raw-byte docs
    queue_text("Hi. Yo!");
    doc_text = {doc_text, ChTab};
    queue_text("Ok?");
    doc_text = {doc_text, ChLf};
    queue_text("Z.");
    doc_text = {doc_text, ChCr};
    send_doc(16'hffff);
    doc_text = {doc_text, 8'h00};
    doc_text = {doc_text, 8'hff};
    send_doc(16'h0000);
    doc_text = {doc_text, 8'hff};
    send_doc(16'h8001);

    // zero target: each sentence its own chunk
    settle();
    write_config(16'd0, 16'd0);
    queue_text("a. b.c d");
    send_doc(16'h1234);

    run_phase(16'd1, 16'd0, 45, 40, 8, 1'b0, 1'b0);
    // tiny sentences under a huge target fill the window
    run_phase(16'hffff, 16'hffff, 55, 70, 1, 1'b0, 1'b0);
    run_phase(16'd12, 16'd6, 45, 50, 6, 1'b1, 1'b0);
    calm = 1'b1;
    run_phase(16'd40, 16'd12, 45, 50, 10, 1'b0, 1'b0);
    calm = 1'b0;
    run_phase(16'($urandom_range(64, 8)), 16'($urandom_range(30)), 45, 50, 10, 1'b0, 1'b1);
    run_phase(16'($urandom_range(16'hffff, 1)), 16'($urandom_range(16'hffff)), 50, 60, 12,
              1'b0, 1'b0);

    wait_drained();
    repeat (QuietCycles) @(posedge clk);
    chunk_check.flush_leftover();
    if (chunk_check.mismatches == 0) begin
      $display("sentence_chunker_with_overlap_top test passed");
    end else begin
      $display("sentence_chunker_with_overlap_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/schunk_pkg.sv
hdl/schunk_ram.sv
hdl/sentence_chunker_with_overlap_top.sv
verif/tb_sentence_chunker_with_overlap_top.sv
